// ===== hw/rtl/ilst_pkg.sv =====
// Shared types, command and error codes for the indexed list store.
package ilst_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W   = 4;
    localparam int IDX_W   = 7;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 48;

    localparam logic [CMD_W-1:0] CMD_GET    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_POP    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_RESIZE = 4'd7;
    localparam logic [CMD_W-1:0] CMD_FRONT  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_BACK   = 4'd9;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_FULL  = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOK,
        S_SHR,
        S_SHW,
        S_WRV,
        S_FILL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic wr_en;
        logic wr_shift;
        logic ptr_step;
        logic finish;
    } t_ctrl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             err_any;
        logic             more;
        logic             out_free;
    } t_stat;

endpackage

// ===== hw/rtl/ilst_ctrl.sv =====
// Command sequencer for the indexed list store.
module ilst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ilst_pkg::t_stat i_stat,
    output ilst_pkg::t_ctrl o_ctrl
);
    import ilst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.err_any) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_stat.cmd)
                        CMD_SET, CMD_PUSH:             n_state = S_WRV;
                        CMD_GET, CMD_FRONT, CMD_BACK:  n_state = S_LOOK;
                        CMD_INSERT: n_state = i_stat.more ? S_SHR : S_WRV;
                        CMD_ERASE:  n_state = i_stat.more ? S_SHR : S_DONE;
                        CMD_RESIZE: n_state = i_stat.more ? S_FILL : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_LOOK: begin
                o_ctrl.rd_en = 1'b1;
                n_state      = S_DONE;
            end
            S_SHR: begin
                o_ctrl.rd_en = 1'b1;
                n_state      = S_SHW;
            end
            S_SHW: begin
                o_ctrl.wr_en    = 1'b1;
                o_ctrl.wr_shift = 1'b1;
                o_ctrl.ptr_step = 1'b1;
                n_state         = S_DECODE;
            end
            S_WRV: begin
                o_ctrl.wr_en = 1'b1;
                n_state      = S_DONE;
            end
            S_FILL: begin
                o_ctrl.wr_en    = 1'b1;
                o_ctrl.ptr_step = 1'b1;
                n_state         = S_DECODE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/ilst_dp.sv =====
// Datapath for the indexed list store: cell memory, count, pointer and result register.
module ilst_dp #(
    parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ilst_pkg::t_ctrl             i_ctrl,
    output ilst_pkg::t_stat             o_stat,
    input  logic [ilst_pkg::IN_W-1:0]   i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ilst_pkg::OUT_W-1:0]  o_out_data
);
    import ilst_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > IDX_W) ? CW : IDX_W) + 1;
    localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

    logic [CMD_W-1:0] in_cmd;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] in_nsz;
    logic [VAL_W-1:0] in_val;

    assign in_cmd = i_in_data[3:0];
    assign in_idx = i_in_data[10:4];
    assign in_val = i_in_data[42:11];
    assign in_nsz = i_in_data[49:43];

    logic [CMD_W-1:0] r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_nsz;
    logic [VAL_W-1:0] r_val;
    t_err             r_err;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_ptr;
    logic [VAL_W-1:0] r_rdata;
    logic [VAL_W-1:0] r_mem [CAPACITY];

    logic             r_out_valid;
    logic [VAL_W-1:0] r_rv;
    logic [CNT_W-1:0] r_ec;
    t_err             r_eo;

    t_err          n_err;
    logic [CW-1:0] n_ptr;
    logic [CW-1:0] n_count;
    logic [CMPW-1:0] cnt_x, idx_x, nsz_x, ptr_x;
    logic [AW-1:0] rd_addr;
    logic [VAL_W-1:0] wr_data;

    assign cnt_x = CMPW'(r_count);
    assign idx_x = CMPW'(in_idx);
    assign nsz_x = CMPW'(in_nsz);
    assign ptr_x = CMPW'(r_ptr);

    // Check at accept, against the count before the command
    always_comb begin
        n_err = ERR_OK;
        n_ptr = r_count;
        unique case (in_cmd)
            CMD_GET, CMD_SET, CMD_ERASE: begin
                n_ptr = CW'(in_idx);
                if (idx_x >= cnt_x) n_err = ERR_RANGE;
            end
            CMD_INSERT: begin
                if (idx_x > cnt_x) n_err = ERR_RANGE;
                else if (cnt_x >= CAP_C) n_err = ERR_FULL;
            end
            CMD_PUSH: begin
                if (cnt_x >= CAP_C) n_err = ERR_FULL;
            end
            CMD_POP: begin
                if (r_count == '0) n_err = ERR_EMPTY;
            end
            CMD_RESIZE: begin
                if (nsz_x > CAP_C) n_err = ERR_FULL;
            end
            CMD_FRONT: begin
                n_ptr = '0;
                if (r_count == '0) n_err = ERR_EMPTY;
            end
            CMD_BACK: begin
                n_ptr = r_count - CW'(1);
                if (r_count == '0) n_err = ERR_EMPTY;
            end
            default: n_err = ERR_OK;
        endcase
    end

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.err_any  = (r_err != ERR_OK);
        o_stat.out_free = !r_out_valid || i_out_ready;
        unique case (r_cmd)
            CMD_INSERT: o_stat.more = ptr_x > CMPW'(r_idx);
            CMD_ERASE:  o_stat.more = (ptr_x + CMPW'(1)) < cnt_x;
            CMD_RESIZE: o_stat.more = ptr_x < CMPW'(r_nsz);
            default:    o_stat.more = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_cmd)
            CMD_INSERT: rd_addr = AW'(r_ptr - CW'(1));
            CMD_ERASE:  rd_addr = AW'(r_ptr + CW'(1));
            default:    rd_addr = AW'(r_ptr);
        endcase
    end

    assign wr_data = i_ctrl.wr_shift ? r_rdata : r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[AW'(r_ptr)] <= wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= in_cmd;
            r_idx <= in_idx;
            r_nsz <= in_nsz;
            r_val <= in_val;
            r_err <= n_err;
            r_ptr <= n_ptr;
        end else if (i_ctrl.ptr_step) begin
            r_ptr <= (r_cmd == CMD_INSERT) ? r_ptr - CW'(1) : r_ptr + CW'(1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (r_err == ERR_OK) begin
            unique case (r_cmd)
                CMD_INSERT, CMD_PUSH: n_count = r_count + CW'(1);
                CMD_ERASE, CMD_POP:   n_count = r_count - CW'(1);
                CMD_CLEAR:            n_count = '0;
                CMD_RESIZE:           n_count = CW'(r_nsz);
                default:              n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            r_ec <= CNT_W'(n_count);
            r_eo <= r_err;
            if (r_err == ERR_OK &&
                (r_cmd == CMD_GET || r_cmd == CMD_FRONT || r_cmd == CMD_BACK)) begin
                r_rv <= r_rdata;
            end else begin
                r_rv <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_W - VAL_W - CNT_W - 2){1'b0}}, r_eo, r_ec, r_rv};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CAP_C)
        else $error("count above capacity");
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.wr_en |-> CMPW'(r_ptr) < CAP_C)
        else $error("write beyond capacity");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");
    a_err_zero_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_eo != ERR_OK) |-> r_rv == '0)
        else $error("read value nonzero on error");
    a_err_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.finish && r_err != ERR_OK) |=> $stable(r_count))
        else $error("failed command changed count");
`endif

endmodule

// ===== hw/rtl/indexed_list_store_core.sv =====
// Top level of the indexed list store: ordered list of 32-bit words with insert and erase.
// Get, front and back read a cell in S_LOOK; set and push write one in S_WRV; pop, clear and
// failed commands write none. Insert and erase read and write each moved element in S_SHR and
// S_SHW, resize writes each filled slot in S_FILL: the cell memory moves one word at a time.
// Throughput: one command at a time; the next is taken the cycle after the result is registered.
// Reset (i_rst_n low, synchronous) empties the list; cell contents are not cleared.
module indexed_list_store_core #(
    parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // cmd[3:0], index[10:4], value[42:11], target_count[49:43], zero pad to 56
    input  logic [ilst_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // read_value[31:0], element_count[38:32], error_code[40:39], zero pad to 48
    output logic [ilst_pkg::OUT_W-1:0] m_axis_tdata
);
    import ilst_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    ilst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    ilst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
